// File: design/wfsp_pkg.sv
// Shared types and constants for the WAV float stream parser.
// Depends on nothing; wfsp_result_fifo and the parser top level import it.
package wfsp_pkg;

	// Chunk and file tags, big-endian as they shift in.
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// File and format limits.
	localparam int unsigned MIN_FILE_BYTES = 44;
	localparam int unsigned FMT_MIN_LEN    = 16;
	localparam int unsigned FMT_BITS_OFS   = 14;
	localparam int unsigned FMT_FLOAT_CODE = 3;
	localparam int unsigned FLOAT_BITS     = 32;

	// Result queue geometry.
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

	// End-of-file status codes.
	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_SHORT      = 4'd1,
		ST_BAD_TAGS   = 4'd2,
		ST_OVERRUN    = 4'd3,
		ST_FMT_SHORT  = 4'd4,
		ST_BAD_FORMAT = 4'd5,
		ST_NO_DATA    = 4'd6,
		ST_MISALIGNED = 4'd7,
		ST_EMPTY      = 4'd8
	} status_t;

	// One result beat.
	typedef struct packed {
		logic        result_kind;
		logic [31:0] sample_bits;
		logic        chunk_first;
		status_t     status_code;
		logic        end_mark;
	} result_t;

	// Results produced by one accepted byte, in order.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// File: design/wfsp_byte_if.sv
// Byte input channel of the WAV float stream parser.
// Carries valid, ready and one file byte with its last-byte mark.
interface wfsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       final_byte;

	modport source(output valid, byte_value, final_byte, input ready);
	modport sink(input valid, byte_value, final_byte, output ready);
endinterface

// File: design/wfsp_result_if.sv
// Result output channel of the WAV float stream parser.
// Carries valid, ready and one sample or status result.
interface wfsp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] sample_bits;
	logic        chunk_first;
	logic [3:0]  status_code;
	logic        end_mark;

	modport source(output valid, result_kind, sample_bits, chunk_first, status_code, end_mark,
		input ready);
	modport sink(input valid, result_kind, sample_bits, chunk_first, status_code, end_mark,
		output ready);
endinterface

// File: design/wfsp_result_fifo.sv
// Small result queue that takes up to two results per cycle and drives the output channel.
// Depends on wfsp_pkg and wfsp_result_if.
module wfsp_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wfsp_pkg::push_t       push,
	output logic                  space_ok,
	wfsp_result_if.source         out_ch
);
	import wfsp_pkg::*;

	result_t                mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   count_q;
	logic [RES_PTR_W-1:0]   wr_ptr_nx;
	logic                   pop;

	assign pop       = out_ch.valid & out_ch.ready;
	assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

	// Room for the worst case of two results from the next byte.
	assign space_ok = (count_q <= RES_CNT_W'(RES_DEPTH - 2));

	// Storage writes; one or two entries per cycle.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
		end
	end

	// Head entry drives the output beat.
	assign out_ch.valid       = (count_q != '0);
	assign out_ch.result_kind = mem_q[rd_ptr_q].result_kind;
	assign out_ch.sample_bits = mem_q[rd_ptr_q].sample_bits;
	assign out_ch.chunk_first = mem_q[rd_ptr_q].chunk_first;
	assign out_ch.status_code = mem_q[rd_ptr_q].status_code;
	assign out_ch.end_mark    = mem_q[rd_ptr_q].end_mark;

	// The queue never holds more than its depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	// Nothing is pushed when there is no room for two.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		!space_ok |-> push.cnt == 2'd0)
		else $error("push into a full result queue");

	// A push into an empty queue shows up on the output next cycle.
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && push.cnt != 2'd0) |=> out_ch.valid)
		else $error("pushed result not presented");

endmodule

// File: design/wav_float_stream_parser.sv
// WAV float stream parser top level: byte-wise RIFF/WAVE chunk walker with sample output.
// Depends on wfsp_pkg, wfsp_byte_if, wfsp_result_if and wfsp_result_fifo.
// When the queue is empty, a result is on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the last byte of a file yields up to two results.
// The input stalls only when the four-entry result queue has fewer than two free slots.
// Reset (arst_n low, asynchronous) clears parser state and empties the result queue.
module wav_float_stream_parser (
	input  logic           clk,
	input  logic           arst_n,
	wfsp_byte_if.sink      in_ch,
	wfsp_result_if.source  out_ch
);
	import wfsp_pkg::*;

	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_HEAD = 3'd1,
		PH_BODY = 3'd2,
		PH_PAD  = 3'd3,
		PH_SINK = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_FMT   = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	// Parser state.
	phase_t       phase_q,       phase_nx;
	logic [3:0]   hdr_pos_q,     hdr_pos_nx;
	logic [31:0]  tag_q,         tag_nx;
	logic [31:0]  chunk_len_q,   chunk_len_nx;
	logic [31:0]  body_left_q,   body_left_nx;
	logic [4:0]   body_off_q,    body_off_nx;
	kind_t        kind_q,        kind_nx;
	logic [7:0]   low_hold_q,    low_hold_nx;
	logic [15:0]  fmt_tag_q,     fmt_tag_nx;
	logic [15:0]  chan_cnt_q,    chan_cnt_nx;
	logic [15:0]  samp_w_q,      samp_w_nx;
	logic         data_found_q,  data_found_nx;
	logic [1:0]   dlen_lo_q,     dlen_lo_nx;
	logic         dlen_zero_q,   dlen_zero_nx;
	logic [23:0]  accum_q,       accum_nx;
	logic [1:0]   word_idx_q,    word_idx_nx;
	logic         first_pend_q,  first_pend_nx;
	status_t      err_q,         err_nx;
	logic [5:0]   byte_total_q,  byte_total_nx;

	logic         accept;
	logic         fin;
	logic [7:0]   b;
	logic         smp_valid;
	logic [31:0]  smp_bits;
	logic         smp_first;
	status_t      status;
	kind_t        new_kind;
	logic         space_ok;
	push_t        push;
	result_t      smp_res;
	result_t      st_res;

	assign accept      = in_ch.valid & in_ch.ready;
	assign in_ch.ready = space_ok;
	assign b           = in_ch.byte_value;
	assign fin         = in_ch.final_byte;

	// Kind of the chunk whose header completes.
	always_comb begin
		if (tag_q == TAG_FMT) begin
			new_kind = KIND_FMT;
		end else if (tag_q == TAG_DATA) begin
			new_kind = KIND_DATA;
		end else begin
			new_kind = KIND_OTHER;
		end
	end

	// Per-byte parse step.
	always_comb begin
		phase_nx      = phase_q;
		hdr_pos_nx    = hdr_pos_q;
		tag_nx        = tag_q;
		chunk_len_nx  = chunk_len_q;
		body_left_nx  = body_left_q;
		body_off_nx   = body_off_q;
		kind_nx       = kind_q;
		low_hold_nx   = low_hold_q;
		fmt_tag_nx    = fmt_tag_q;
		chan_cnt_nx   = chan_cnt_q;
		samp_w_nx     = samp_w_q;
		data_found_nx = data_found_q;
		dlen_lo_nx    = dlen_lo_q;
		dlen_zero_nx  = dlen_zero_q;
		accum_nx      = accum_q;
		word_idx_nx   = word_idx_q;
		first_pend_nx = first_pend_q;
		err_nx        = err_q;
		byte_total_nx = byte_total_q;
		smp_valid     = 1'b0;
		smp_bits      = {b, accum_q};
		smp_first     = first_pend_q;

		if (byte_total_q < 6'(MIN_FILE_BYTES)) begin
			byte_total_nx = byte_total_q + 6'd1;
		end

		case (phase_q)
			PH_RIFF: begin
				tag_nx = {tag_q[23:0], b};
				if (hdr_pos_q == 4'd3 && tag_nx != TAG_RIFF) begin
					err_nx   = ST_BAD_TAGS;
					phase_nx = PH_SINK;
				end else if (hdr_pos_q == 4'd11) begin
					if (tag_nx != TAG_WAVE) begin
						err_nx   = ST_BAD_TAGS;
						phase_nx = PH_SINK;
					end else begin
						phase_nx   = PH_HEAD;
						hdr_pos_nx = 4'd0;
					end
				end else begin
					hdr_pos_nx = hdr_pos_q + 4'd1;
				end
			end
			PH_HEAD: begin
				if (hdr_pos_q < 4'd4) begin
					tag_nx = {tag_q[23:0], b};
					if (hdr_pos_q == 4'd0) begin
						chunk_len_nx = '0;
					end
				end else begin
					chunk_len_nx = chunk_len_q | (32'(b) << {hdr_pos_q[1:0], 3'b000});
				end
				hdr_pos_nx = hdr_pos_q + 4'd1;
				// Header complete: set up the body walk.
				if (hdr_pos_q == 4'd7) begin
					kind_nx       = new_kind;
					body_left_nx  = chunk_len_nx;
					body_off_nx   = '0;
					accum_nx      = '0;
					word_idx_nx   = '0;
					first_pend_nx = (new_kind == KIND_DATA);
					if (new_kind == KIND_DATA) begin
						data_found_nx = 1'b1;
						dlen_lo_nx    = chunk_len_nx[1:0];
						dlen_zero_nx  = (chunk_len_nx == '0);
					end
					if (chunk_len_nx == '0) begin
						hdr_pos_nx = 4'd0;
						if (new_kind == KIND_FMT) begin
							err_nx   = ST_FMT_SHORT;
							phase_nx = PH_SINK;
						end else begin
							phase_nx = PH_HEAD;
						end
					end else begin
						phase_nx = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (kind_q == KIND_FMT) begin
					if (body_off_q[0]) begin
						if (body_off_q == 5'd1) begin
							fmt_tag_nx = {b, low_hold_q};
						end else if (body_off_q == 5'd3) begin
							chan_cnt_nx = {b, low_hold_q};
						end else if (body_off_q == 5'(FMT_BITS_OFS + 1)) begin
							samp_w_nx = {b, low_hold_q};
						end
					end else begin
						low_hold_nx = b;
					end
				end else if (kind_q == KIND_DATA) begin
					// Little-endian word assembly; the fourth byte completes a sample.
					if (word_idx_q == 2'd3) begin
						smp_valid     = 1'b1;
						first_pend_nx = 1'b0;
						accum_nx      = '0;
						word_idx_nx   = '0;
					end else begin
						accum_nx    = accum_q | (24'(b) << {word_idx_q, 3'b000});
						word_idx_nx = word_idx_q + 2'd1;
					end
				end
				if (body_off_q < 5'(FMT_MIN_LEN)) begin
					body_off_nx = body_off_q + 5'd1;
				end
				body_left_nx = body_left_q - 32'd1;
				// Body finished: check fmt length, then pad or next header.
				if (body_left_q == 32'd1) begin
					hdr_pos_nx = 4'd0;
					if (kind_q == KIND_FMT && chunk_len_q < 32'(FMT_MIN_LEN)) begin
						err_nx   = ST_FMT_SHORT;
						phase_nx = PH_SINK;
					end else if (chunk_len_q[0]) begin
						phase_nx = PH_PAD;
					end else begin
						phase_nx = PH_HEAD;
					end
				end
			end
			PH_PAD: begin
				phase_nx   = PH_HEAD;
				hdr_pos_nx = 4'd0;
			end
			default: begin
			end
		endcase
	end

	// End-of-file status, from the state after this byte.
	always_comb begin
		if (byte_total_nx < 6'(MIN_FILE_BYTES)) begin
			status = ST_SHORT;
		end else if (err_nx != ST_OK) begin
			status = err_nx;
		end else if (phase_nx == PH_BODY) begin
			status = ST_OVERRUN;
		end else if (fmt_tag_nx != 16'(FMT_FLOAT_CODE) || chan_cnt_nx != 16'd1
				|| samp_w_nx != 16'(FLOAT_BITS)) begin
			status = ST_BAD_FORMAT;
		end else if (!data_found_nx) begin
			status = ST_NO_DATA;
		end else if (dlen_lo_nx != 2'd0) begin
			status = ST_MISALIGNED;
		end else if (dlen_zero_nx) begin
			status = ST_EMPTY;
		end else begin
			status = ST_OK;
		end
	end

	// Results of this beat, sample first.
	always_comb begin
		smp_res = '{result_kind: 1'b0, sample_bits: smp_bits, chunk_first: smp_first,
			status_code: ST_OK, end_mark: 1'b0};
		st_res  = '{result_kind: 1'b1, sample_bits: 32'd0, chunk_first: 1'b0,
			status_code: status, end_mark: 1'b1};
		push.first  = smp_valid ? smp_res : st_res;
		push.second = st_res;
		if (!accept) begin
			push.cnt = 2'd0;
		end else begin
			push.cnt = 2'(smp_valid) + 2'(fin);
		end
	end

	// State registers; the last byte of a file returns to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RIFF;
			hdr_pos_q    <= '0;
			tag_q        <= '0;
			chunk_len_q  <= '0;
			body_left_q  <= '0;
			body_off_q   <= '0;
			kind_q       <= KIND_OTHER;
			low_hold_q   <= '0;
			fmt_tag_q    <= '0;
			chan_cnt_q   <= '0;
			samp_w_q     <= '0;
			data_found_q <= 1'b0;
			dlen_lo_q    <= '0;
			dlen_zero_q  <= 1'b0;
			accum_q      <= '0;
			word_idx_q   <= '0;
			first_pend_q <= 1'b0;
			err_q        <= ST_OK;
			byte_total_q <= '0;
		end else if (accept) begin
			if (fin) begin
				phase_q      <= PH_RIFF;
				hdr_pos_q    <= '0;
				tag_q        <= '0;
				chunk_len_q  <= '0;
				body_left_q  <= '0;
				body_off_q   <= '0;
				kind_q       <= KIND_OTHER;
				low_hold_q   <= '0;
				fmt_tag_q    <= '0;
				chan_cnt_q   <= '0;
				samp_w_q     <= '0;
				data_found_q <= 1'b0;
				dlen_lo_q    <= '0;
				dlen_zero_q  <= 1'b0;
				accum_q      <= '0;
				word_idx_q   <= '0;
				first_pend_q <= 1'b0;
				err_q        <= ST_OK;
				byte_total_q <= '0;
			end else begin
				phase_q      <= phase_nx;
				hdr_pos_q    <= hdr_pos_nx;
				tag_q        <= tag_nx;
				chunk_len_q  <= chunk_len_nx;
				body_left_q  <= body_left_nx;
				body_off_q   <= body_off_nx;
				kind_q       <= kind_nx;
				low_hold_q   <= low_hold_nx;
				fmt_tag_q    <= fmt_tag_nx;
				chan_cnt_q   <= chan_cnt_nx;
				samp_w_q     <= samp_w_nx;
				data_found_q <= data_found_nx;
				dlen_lo_q    <= dlen_lo_nx;
				dlen_zero_q  <= dlen_zero_nx;
				accum_q      <= accum_nx;
				word_idx_q   <= word_idx_nx;
				first_pend_q <= first_pend_nx;
				err_q        <= err_nx;
				byte_total_q <= byte_total_nx;
			end
		end
	end

	// Result queue and output channel.
	wfsp_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.out_ch   (out_ch)
	);

	// The sink phase is only entered through an error.
	a_sink_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SINK |-> err_q != ST_OK)
		else $error("sink phase without a latched error");

	// A body in progress always has bytes left.
	a_body_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_left_q != '0)
		else $error("body phase with nothing left");

	// The last byte of a file starts the next file from scratch.
	a_file_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fin) |=> (phase_q == PH_RIFF && byte_total_q == '0 && err_q == ST_OK))
		else $error("parser not reset after the last byte");

	// Partial words are only ever gathered from a data chunk.
	a_word_idx: assert property (@(posedge clk) disable iff (!arst_n)
		word_idx_q != 2'd0 |-> kind_q == KIND_DATA)
		else $error("partial word outside a data chunk");

endmodule
